/* hdl/kwc_pkg.sv */
// Shared types and constants of the k-mer window counter.
`timescale 1ns / 1ps
package kwc_pkg;

  localparam int KEY_W     = 64;
  localparam int IDX_W     = 10;
  localparam int SYM_W     = 8;
  localparam int WS_W      = 5;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CODE_W    = 4;
  localparam int DW_OUT_W  = 11;
  localparam int CNT_OUT_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORD_SIZE = 2'd0,
    CFG_MIN_COUNT = 2'd1
  } cfg_reg_e;

  // One unit of work handed from the front end to the table engine
  typedef struct packed {
    logic             rd;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } task_t;

  // Fold to upper case and map ACGRSTUWY to 0..8; MSB flags a valid letter
  function automatic logic [CODE_W:0] letter_code(input logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] up;
    logic [CODE_W:0]  res;
    up = (sym >= 8'h61 && sym <= 8'h7A) ? sym - 8'd32 : sym;
    unique case (up)
      8'h41:   res = {1'b1, 4'd0};
      8'h43:   res = {1'b1, 4'd1};
      8'h47:   res = {1'b1, 4'd2};
      8'h52:   res = {1'b1, 4'd3};
      8'h53:   res = {1'b1, 4'd4};
      8'h54:   res = {1'b1, 4'd5};
      8'h55:   res = {1'b1, 4'd6};
      8'h57:   res = {1'b1, 4'd7};
      8'h59:   res = {1'b1, 4'd8};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

/* hdl/kmer_window_counter_core.sv */
// Top level of the k-mer window counter.
`timescale 1ns / 1ps
// Characters are taken through a queue-style port (push/full); each one shifts
// a window, and every complete window becomes a lookup task in a four-entry
// task queue. The table engine behind it resolves a word through a hash index
// with linear probing (2*TABLE_DEPTH slots, no clearing pass needed) and a
// key/count memory pair. A probe steps through hash read, id read, key read
// and compare states, then the engine returns to idle; on a collision it
// probes the adjacent slot. Feeds that form no word push no task. A read
// command reads the key and count RAMs and its result sits in an output
// register until popped (empty/pop); configuration (cfg_valid_i/cfg_ready_o) is always ready.
module kmer_window_counter_core #(
  parameter int MAX_WORD    = 16,
  parameter int TABLE_DEPTH = 1024,
  parameter int COUNT_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              cmd_i,
  input  logic [kwc_pkg::SYM_W-1:0]         symbol_i,
  input  logic                              end_of_read_i,
  input  logic [kwc_pkg::IDX_W-1:0]         entry_index_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [kwc_pkg::KEY_W-1:0]         word_key_o,
  output logic [kwc_pkg::CNT_OUT_W-1:0]     word_count_o,
  output logic                              entry_present_o,
  output logic                              meets_min_o,
  output logic [kwc_pkg::DW_OUT_W-1:0]      distinct_words_o,
  output logic                              table_overflow_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kwc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [kwc_pkg::CFG_W-1:0]         cfg_data_i
);
  import kwc_pkg::*;

  logic [WS_W-1:0]  ws_q;
  logic [CFG_W-1:0] min_q;
  logic             q_full, q_empty, q_push, q_pop, accept;
  task_t            f_task, b_task;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q  <= WS_W'(8);
      min_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WORD_SIZE) begin
        ws_q <= cfg_data_i[WS_W-1:0];
      end else if (cfg_index_i == CFG_MIN_COUNT) begin
        min_q <= cfg_data_i;
      end
    end
  end

  assign accept = push && !q_full;
  assign full   = q_full;

  kwc_front #(.MAX_WORD(MAX_WORD)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .cmd_i, .symbol_i, .end_of_read_i,
    .entry_index_i, .word_size_i(ws_q), .push_o(q_push), .task_o(f_task)
  );

  kwc_queue #(.DEPTH(4)) u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .wdata_i(f_task), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .rdata_o(b_task)
  );

  kwc_back #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_task_i(b_task), .q_pop_o(q_pop),
    .min_count_i(min_q), .pop_i(pop), .empty_o(empty),
    .word_key_o, .word_count_o, .entry_present_o, .meets_min_o,
    .distinct_words_o, .table_overflow_o
  );
endmodule

/* hdl/kwc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hdl/kwc_front.sv */
// Front end: letter coding, sliding window, valid run, task issue.
`timescale 1ns / 1ps
module kwc_front #(
  parameter int MAX_WORD = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        cmd_i,
  input  logic [kwc_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        end_of_read_i,
  input  logic [kwc_pkg::IDX_W-1:0]   entry_index_i,
  input  logic [kwc_pkg::WS_W-1:0]    word_size_i,
  output logic                        push_o,
  output kwc_pkg::task_t              task_o
);
  import kwc_pkg::*;

  localparam int WW   = 4 * MAX_WORD;
  localparam int RUNW = $clog2(MAX_WORD + 1);

  logic [WW-1:0]     win_q, win_d, win_n, mask;
  logic [RUNW-1:0]   run_q, run_d, run_n;
  logic [CODE_W:0]   lc;
  logic [WS_W-1:0]   ws_c;
  logic              form;

  // Clamp word size to 1..MAX_WORD
  always_comb begin
    if (word_size_i == '0) begin
      ws_c = WS_W'(1);
    end else if (32'(word_size_i) > MAX_WORD) begin
      ws_c = WS_W'(MAX_WORD);
    end else begin
      ws_c = word_size_i;
    end
    for (int i = 0; i < MAX_WORD; i++) begin
      mask[4*i +: 4] = (i < 32'(ws_c)) ? 4'hF : 4'h0;
    end
  end

  // Shift in the new code, or restart on a non-letter or at end of read
  always_comb begin
    lc = letter_code(symbol_i);
    if (lc[CODE_W]) begin
      win_n = (win_q << 4) | WW'(lc[CODE_W-1:0]);
      run_n = (32'(run_q) < MAX_WORD) ? run_q + RUNW'(1) : run_q;
      form  = 6'(run_n) >= 6'(ws_c);
    end else begin
      win_n = '0;
      run_n = '0;
      form  = 1'b0;
    end
    win_d = win_q;
    run_d = run_q;
    if (accept_i && !cmd_i) begin
      win_d = end_of_read_i ? '0 : win_n;
      run_d = end_of_read_i ? '0 : run_n;
    end
  end

  assign push_o     = accept_i && (cmd_i || form);
  assign task_o.rd  = cmd_i;
  assign task_o.key = KEY_W'(win_n & mask);
  assign task_o.idx = entry_index_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      run_q <= '0;
    end else begin
      win_q <= win_d;
      run_q <= run_d;
    end
  end
endmodule

/* hdl/kwc_queue.sv */
// Short task queue between front end and table engine.
`timescale 1ns / 1ps
module kwc_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kwc_pkg::task_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output kwc_pkg::task_t rdata_o
);
  import kwc_pkg::*;

  localparam int AW = $clog2(DEPTH);

  task_t             slots [DEPTH];
  logic [AW-1:0]     wptr_q, rptr_q;
  logic [AW:0]       cnt_q;

  assign full_o  = cnt_q == (AW + 1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = slots[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wptr_q] <= wdata_i;
    end
  end

  // Pointers wrap at DEPTH
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + AW'(1);
      end
      cnt_q <= cnt_q + (AW + 1)'(push_i) - (AW + 1)'(pop_i);
    end
  end
endmodule

/* hdl/kwc_back.sv */
// Table engine: hashed lookup, insert, count update, entry read, result register.
`timescale 1ns / 1ps
module kwc_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COUNT_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  kwc_pkg::task_t                  q_task_i,
  output logic                            q_pop_o,
  input  logic [kwc_pkg::CFG_W-1:0]       min_count_i,
  input  logic                            pop_i,
  output logic                            empty_o,
  output logic [kwc_pkg::KEY_W-1:0]       word_key_o,
  output logic [kwc_pkg::CNT_OUT_W-1:0]   word_count_o,
  output logic                            entry_present_o,
  output logic                            meets_min_o,
  output logic [kwc_pkg::DW_OUT_W-1:0]    distinct_words_o,
  output logic                            table_overflow_o
);
  import kwc_pkg::*;

  localparam int IDW   = $clog2(TABLE_DEPTH);
  localparam int UW    = $clog2(TABLE_DEPTH + 1);
  localparam int SLOTW = IDW + 1;
  localparam int HDEP  = 2 * TABLE_DEPTH;
  localparam int KRW   = KEY_W + SLOTW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HASH = 7'b0000010,
    S_HID  = 7'b0000100,
    S_KEY  = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_RKEY = 7'b0100000,
    S_RRES = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SLOTW-1:0]    slot_q, slot_d;
  logic [IDW-1:0]      kaddr_q, kaddr_d;
  logic [UW-1:0]       used_q, used_d;
  logic                ovf_q, ovf_d;

  // Memory ports
  logic                h_we, k_we, c_we;
  logic [IDW-1:0]      h_rdata, k_waddr, c_waddr;
  logic [IDW-1:0]      h_wdata;
  logic [KRW-1:0]      k_rdata, k_wdata;
  logic [COUNT_BITS-1:0] c_rdata, c_wdata;

  // Result register
  logic                ov_q, ov_d;
  logic [KEY_W-1:0]    okey_q, okey_d;
  logic [CNT_OUT_W-1:0] ocnt_q, ocnt_d;
  logic                opres_q, opres_d, omin_q, omin_d;
  logic [DW_OUT_W-1:0] odw_q, odw_d;
  logic                oovf_q, oovf_d;

  logic                occupied, hit, present, out_free;
  logic [SLOTW-1:0]    hash_v;

  // XOR fold of the key onto the slot index
  always_comb begin
    hash_v = '0;
    for (int i = 0; i < KEY_W; i++) begin
      hash_v[i % SLOTW] = hash_v[i % SLOTW] ^ q_task_i.key[i];
    end
  end

  kwc_ram #(.WIDTH(IDW), .DEPTH(HDEP)) u_hash_ram (
    .clk_i, .we_i(h_we), .waddr_i(slot_q), .wdata_i(h_wdata),
    .raddr_i(slot_q), .rdata_o(h_rdata)
  );
  kwc_ram #(.WIDTH(KRW), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk_i, .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .raddr_i(kaddr_q), .rdata_o(k_rdata)
  );
  kwc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_count_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(kaddr_q), .rdata_o(c_rdata)
  );

  // A slot is live only if its id is allocated and that id points back here
  assign occupied = (UW'(kaddr_q) < used_q) && (k_rdata[SLOTW-1:0] == slot_q);
  assign hit      = occupied && (k_rdata[KRW-1:SLOTW] == key_q);
  assign present  = 17'(idx_q) < 17'(used_q);
  assign out_free = !ov_q || pop_i;

  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    idx_d   = idx_q;
    slot_d  = slot_q;
    kaddr_d = kaddr_q;
    used_d  = used_q;
    ovf_d   = ovf_q;
    q_pop_o = 1'b0;
    h_we    = 1'b0;
    h_wdata = IDW'(used_q);
    k_we    = 1'b0;
    k_waddr = IDW'(used_q);
    k_wdata = {key_q, slot_q};
    c_we    = 1'b0;
    c_waddr = IDW'(used_q);
    c_wdata = COUNT_BITS'(1);
    ov_d    = ov_q && !pop_i;
    okey_d  = okey_q;
    ocnt_d  = ocnt_q;
    opres_d = opres_q;
    omin_d  = omin_q;
    odw_d   = odw_q;
    oovf_d  = oovf_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          key_d   = q_task_i.key;
          idx_d   = q_task_i.idx;
          slot_d  = hash_v;
          kaddr_d = IDW'(q_task_i.idx);
          state_d = q_task_i.rd ? S_RKEY : S_HASH;
        end
      end
      S_HASH: state_d = S_HID;
      S_HID: begin
        kaddr_d = h_rdata;
        state_d = S_KEY;
      end
      S_KEY: state_d = S_CMP;
      S_CMP: begin
        if (hit) begin
          // Saturating count update
          c_we    = 1'b1;
          c_waddr = kaddr_q;
          c_wdata = (&c_rdata) ? c_rdata : c_rdata + COUNT_BITS'(1);
          state_d = S_IDLE;
        end else if (occupied) begin
          slot_d  = slot_q + SLOTW'(1);
          state_d = S_HASH;
        end else begin
          if (32'(used_q) < TABLE_DEPTH) begin
            h_we   = 1'b1;
            k_we   = 1'b1;
            c_we   = 1'b1;
            used_d = used_q + UW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_RKEY: state_d = S_RRES;
      S_RRES: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okey_d  = present ? k_rdata[KRW-1:SLOTW] : '0;
          ocnt_d  = present ? CNT_OUT_W'(c_rdata) : '0;
          opres_d = present;
          omin_d  = present && (CNT_OUT_W'(c_rdata) >= min_count_i);
          odw_d   = DW_OUT_W'(used_q);
          oovf_d  = ovf_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    kaddr_q <= kaddr_d;
    okey_q  <= okey_d;
    ocnt_q  <= ocnt_d;
    opres_q <= opres_d;
    omin_q  <= omin_d;
    odw_q   <= odw_d;
    oovf_q  <= oovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  assign empty_o          = !ov_q;
  assign word_key_o       = okey_q;
  assign word_count_o     = ocnt_q;
  assign entry_present_o  = opres_q;
  assign meets_min_o      = omin_q;
  assign distinct_words_o = odw_q;
  assign table_overflow_o = oovf_q;
endmodule
